/* sv/odm_pkg.sv */
package odm_pkg;

	// direction codes of a drive command
	localparam logic [2:0] DIR_BRAKE    = 3'd0;
	localparam logic [2:0] DIR_FORWARD  = 3'd1;
	localparam logic [2:0] DIR_BACKWARD = 3'd2;
	localparam logic [2:0] DIR_LEFT     = 3'd3;
	localparam logic [2:0] DIR_RIGHT    = 3'd4;
	localparam logic [2:0] DIR_ROTATE   = 3'd5;
	localparam logic [2:0] DIR_STANDBY  = 3'd6;

	// motor drive states
	localparam logic [1:0] DRV_STANDBY  = 2'd0;
	localparam logic [1:0] DRV_FORWARD  = 2'd1;
	localparam logic [1:0] DRV_BACKWARD = 2'd2;
	localparam logic [1:0] DRV_BRAKE    = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_STRAIGHT_OFFSET   = 3'd0;
	localparam logic [2:0] REG_LATERAL_OFFSET    = 3'd1;
	localparam logic [2:0] REG_GAIN_PROPORTIONAL = 3'd2;
	localparam logic [2:0] REG_GAIN_INTEGRAL     = 3'd3;
	localparam logic [2:0] REG_GAIN_DERIVATIVE   = 3'd4;

	localparam logic signed [23:0] GAIN_P_RESET = 24'sd62915;
	localparam logic signed [23:0] GAIN_I_RESET = 24'sd0;
	localparam logic signed [23:0] GAIN_D_RESET = 24'sd105;

	localparam logic signed [11:0] STRAIGHT_BASE = 12'sd25;
	localparam logic signed [11:0] LATERAL_BASE  = 12'sd35;
	localparam logic signed [11:0] ROTATE_BASE   = 12'sd65;
	localparam logic signed [11:0] LEVEL_CAP     = 12'sd200;
	localparam logic signed [11:0] ROTATE_CAP    = 12'sd255;
	localparam logic signed [15:0] ROTATE_DEAD   = 16'sd768;

	// estimate = floor(sum * 42.624 + 0.5), reciprocal scaled by 2^24, rounded up
	localparam int               EST_SHIFT = 24;
	localparam logic [29:0]      EST_MUL   = 30'd715112055;
	localparam logic [39:0]      EST_ROUND = 40'd8388608;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic               kind;
		logic [2:0]         direction;
		logic signed [15:0] speed;
		logic signed [15:0] lateral_speed;
		logic signed [15:0] rotation;
		logic signed [15:0] heading_trim;
		logic signed [15:0] flow_delta;
	} in_t;

	typedef struct packed {
		logic [1:0]  drive_front_left;
		logic [1:0]  drive_front_right;
		logic [1:0]  drive_rear_left;
		logic [1:0]  drive_rear_right;
		logic [7:0]  level_front_left;
		logic [7:0]  level_front_right;
		logic [7:0]  level_rear_left;
		logic [7:0]  level_rear_right;
		logic [15:0] estimate_x;
		logic [15:0] estimate_y;
	} out_t;

	// classified word between front and back
	typedef struct packed {
		logic               is_flow;
		logic [2:0]         direction;
		logic signed [15:0] speed;
		logic signed [15:0] lateral_speed;
		logic signed [15:0] rotation;
		logic signed [15:0] heading_trim;
		logic signed [15:0] flow_delta;
	} entry_t;

	typedef struct packed {
		logic signed [23:0] kp;
		logic signed [23:0] ki;
		logic signed [23:0] kd;
	} gains_t;

	// signed divide by 256 rounding toward zero
	function automatic logic signed [11:0] div256_trunc(input logic signed [19:0] v);
		logic signed [11:0] q;
		q = v[19:8];
		if (v[19] && (v[7:0] != 8'd0)) begin
			q = q + 12'sd1;
		end
		return q;
	endfunction

endpackage

/* sv/odm_front.sv */
module odm_front import odm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cmd_valid,
	output logic   cmd_stall,
	input  in_t    cmd,
	output logic   q_valid,
	input  logic   q_pop,
	output entry_t q_word
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	entry_t       mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   count_q;
	logic          push;
	entry_t        cls;

	assign cmd_stall = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign push      = cmd_valid && !cmd_stall;
	assign q_valid   = (count_q != '0);
	assign q_word    = mem_q[rd_q];

	always_comb begin
		cls.is_flow       = cmd.kind;
		cls.direction     = cmd.direction;
		cls.speed         = cmd.speed;
		cls.lateral_speed = cmd.lateral_speed;
		cls.rotation      = cmd.rotation;
		cls.heading_trim  = cmd.heading_trim;
		cls.flow_delta    = cmd.flow_delta;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (q_pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + (PW+1)'(1);
				2'b01:   count_q <= count_q - (PW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* sv/odm_pid.sv */
module odm_pid import odm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               lateral,
	input  logic signed [15:0] delta,
	input  gains_t             gains,
	output logic signed [15:0] trim,
	output logic               busy
);

	logic signed [31:0] drift_q;
	logic signed [31:0] hist0_q;
	logic signed [31:0] hist1_q;
	logic signed [31:0] o_q;
	logic signed [15:0] c_q;

	logic signed [31:0] e_s1;
	logic signed [31:0] h0_s1;
	logic signed [31:0] h1_s1;
	logic signed [57:0] prod0_s2;
	logic signed [57:0] prod1_s2;
	logic signed [57:0] prod2_s2;
	logic signed [59:0] psum_s3;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	logic signed [25:0] a0;
	logic signed [25:0] a1;
	logic signed [32:0] dsum;
	logic signed [31:0] e_n;
	logic signed [61:0] acc;
	logic signed [57:0] acc_sh;
	logic signed [31:0] o_n;
	logic signed [32:0] c_rnd;
	logic signed [24:0] c_sh;
	logic signed [15:0] c_n;

	assign trim = c_q;
	assign busy = vld_s1 || vld_s2 || vld_s3 || vld_s4;

	always_comb begin
		a0 = 26'(gains.kp) + 26'(gains.ki) + 26'(gains.kd);
		a1 = -26'(gains.kp) - (26'(gains.kd) <<< 1);

		dsum = 33'(drift_q) + 33'(delta);
		if (dsum[32] != dsum[31]) begin
			e_n = dsum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			e_n = dsum[31:0];
		end

		// acc + 16 * previous output + rounding, then back to Q16.16
		acc    = 62'(psum_s3) + 62'($signed({o_q, 4'b0000})) + 62'sd8;
		acc_sh = acc[61:4];
		if ((acc_sh[57:31] != '0) && (acc_sh[57:31] != '1)) begin
			o_n = acc_sh[57] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			o_n = acc_sh[31:0];
		end

		c_rnd = 33'(o_q) + 33'sd128;
		c_sh  = c_rnd[32:8];
		if ((c_sh[24:15] != '0) && (c_sh[24:15] != '1)) begin
			c_n = c_sh[24] ? 16'sh8000 : 16'sh7fff;
		end else begin
			c_n = c_sh[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (start && lateral) begin
			e_s1  <= e_n;
			h0_s1 <= hist0_q;
			h1_s1 <= hist1_q;
		end
		prod0_s2 <= a0 * e_s1;
		prod1_s2 <= a1 * h0_s1;
		prod2_s2 <= gains.kd * h1_s1;
		psum_s3  <= 60'(prod0_s2) + 60'(prod1_s2) + 60'(prod2_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drift_q <= '0;
			hist0_q <= '0;
			hist1_q <= '0;
			o_q     <= '0;
			c_q     <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
		end else begin
			vld_s1 <= start && lateral;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			if (start && lateral) begin
				drift_q <= e_n;
				hist0_q <= e_n;
				hist1_q <= hist0_q;
			end else if (start) begin
				// no pid word in flight here, so clearing is safe
				drift_q <= '0;
				hist0_q <= '0;
				hist1_q <= '0;
				o_q     <= '0;
				c_q     <= '0;
			end
			if (vld_s3) begin
				o_q <= o_n;
			end
			if (vld_s4) begin
				c_q <= c_n;
			end
		end
	end

endmodule

/* sv/odm_mixer.sv */
module odm_mixer import odm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	output logic               take_ok,
	input  entry_t             cmd,
	input  logic signed [7:0]  straight_offset,
	input  logic signed [7:0]  lateral_offset,
	input  logic signed [15:0] trim,
	output logic               res_valid,
	input  logic               res_stall,
	output out_t               res
);

	logic [1:0] drv_n [4];
	logic [7:0] lvl_n [4];
	logic [9:0] sum_n;

	logic [1:0] drv_s1 [4];
	logic [7:0] lvl_s1 [4];
	logic [9:0] sum_s1;
	logic       est_x_s1;
	logic       est_y_s1;
	logic       vld_s1;
	out_t       res_s2;
	logic       vld_s2;

	logic        adv;
	logic [39:0] est_prod;
	logic [15:0] est;

	assign adv       = !vld_s2 || !res_stall;
	assign take_ok   = adv || !vld_s1;
	assign res_valid = vld_s2;
	assign res       = res_s2;

	always_comb begin
		logic signed [11:0] spd_t;
		logic signed [11:0] base_st;
		logic signed [11:0] base_lat;
		logic signed [11:0] rot_t;
		logic signed [11:0] rot_abs;
		logic signed [11:0] rot_lvl;
		logic signed [11:0] lane;
		logic signed [19:0] v;
		logic signed [19:0] h;
		logic signed [19:0] c;
		logic               right;
		logic               plus_h;
		logic               plus_c;
		logic               even;

		v        = '0;
		lane     = '0;
		plus_h   = 1'b0;
		plus_c   = 1'b0;
		even     = 1'b0;
		h        = 20'(cmd.heading_trim);
		c        = 20'(trim);
		spd_t    = div256_trunc(20'(cmd.speed));
		base_st  = STRAIGHT_BASE + 12'(straight_offset) + spd_t;
		base_lat = LATERAL_BASE + 12'(lateral_offset);
		rot_t    = div256_trunc(20'(cmd.rotation));
		rot_abs  = rot_t[11] ? -rot_t : rot_t;
		rot_lvl  = ROTATE_BASE + rot_abs;
		if (rot_lvl > ROTATE_CAP) begin
			rot_lvl = ROTATE_CAP;
		end
		right = (cmd.direction == DIR_RIGHT);

		for (int i = 0; i < 4; i++) begin
			drv_n[i] = DRV_STANDBY;
			lvl_n[i] = 8'd0;
		end

		case (cmd.direction)
			DIR_BRAKE: begin
				for (int i = 0; i < 4; i++) begin
					drv_n[i] = DRV_BRAKE;
				end
			end
			DIR_FORWARD, DIR_BACKWARD: begin
				for (int i = 0; i < 4; i++) begin
					v = $signed({base_st, 8'h00});
					if (cmd.direction == DIR_FORWARD) begin
						v = (i == 0 || i == 3) ? v + h : v - h;
					end
					lane = div256_trunc(v);
					if (lane < STRAIGHT_BASE) begin
						drv_n[i] = DRV_BRAKE;
						lvl_n[i] = 8'd0;
					end else begin
						drv_n[i] = (cmd.direction == DIR_FORWARD) ? DRV_FORWARD : DRV_BACKWARD;
						lvl_n[i] = (lane > LEVEL_CAP) ? LEVEL_CAP[7:0] : lane[7:0];
					end
				end
			end
			DIR_LEFT, DIR_RIGHT: begin
				for (int i = 0; i < 4; i++) begin
					even   = (i == 0 || i == 2);
					plus_h = (i < 2) ^ right;
					plus_c = even ^ right;
					v = $signed({base_lat, 8'h00}) + 20'(cmd.lateral_speed);
					v = plus_h ? v + h : v - h;
					v = plus_c ? v + c : v - c;
					lane = div256_trunc(v);
					if (lane < LATERAL_BASE) begin
						drv_n[i] = DRV_BRAKE;
					end else begin
						drv_n[i] = (even ^ right) ? DRV_FORWARD : DRV_BACKWARD;
					end
					// braking lateral lanes still report their level
					if (lane[11]) begin
						lvl_n[i] = 8'd0;
					end else if (lane > LEVEL_CAP) begin
						lvl_n[i] = LEVEL_CAP[7:0];
					end else begin
						lvl_n[i] = lane[7:0];
					end
				end
			end
			DIR_ROTATE: begin
				for (int i = 0; i < 4; i++) begin
					lvl_n[i] = rot_lvl[7:0];
				end
				if (cmd.rotation > ROTATE_DEAD) begin
					drv_n[0] = DRV_FORWARD;
					drv_n[1] = DRV_BACKWARD;
					drv_n[2] = DRV_BACKWARD;
					drv_n[3] = DRV_FORWARD;
				end else if (cmd.rotation < -ROTATE_DEAD) begin
					drv_n[0] = DRV_BACKWARD;
					drv_n[1] = DRV_FORWARD;
					drv_n[2] = DRV_FORWARD;
					drv_n[3] = DRV_BACKWARD;
				end else begin
					for (int i = 0; i < 4; i++) begin
						drv_n[i] = DRV_BRAKE;
					end
				end
			end
			default: begin
				for (int i = 0; i < 4; i++) begin
					drv_n[i] = DRV_STANDBY;
				end
			end
		endcase

		sum_n = 10'(lvl_n[0]) + 10'(lvl_n[1]) + 10'(lvl_n[2]) + 10'(lvl_n[3]);
	end

	assign est_prod = 40'(sum_s1) * 40'(EST_MUL) + EST_ROUND;
	assign est      = est_prod[EST_SHIFT +: 16];

	always_ff @(posedge clk) begin
		if (take_ok && go) begin
			for (int i = 0; i < 4; i++) begin
				drv_s1[i] <= drv_n[i];
				lvl_s1[i] <= lvl_n[i];
			end
			sum_s1   <= sum_n;
			est_x_s1 <= (cmd.direction == DIR_FORWARD) || (cmd.direction == DIR_BACKWARD);
			est_y_s1 <= (cmd.direction == DIR_LEFT) || (cmd.direction == DIR_RIGHT);
		end
		if (adv && vld_s1) begin
			res_s2.drive_front_left  <= drv_s1[0];
			res_s2.drive_front_right <= drv_s1[1];
			res_s2.drive_rear_left   <= drv_s1[2];
			res_s2.drive_rear_right  <= drv_s1[3];
			res_s2.level_front_left  <= lvl_s1[0];
			res_s2.level_front_right <= lvl_s1[1];
			res_s2.level_rear_left   <= lvl_s1[2];
			res_s2.level_rear_right  <= lvl_s1[3];
			res_s2.estimate_x        <= est_x_s1 ? est : 16'd0;
			res_s2.estimate_y        <= est_y_s1 ? est : 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv) begin
				vld_s2 <= vld_s1;
			end
			if (take_ok) begin
				vld_s1 <= go;
			end
		end
	end

endmodule

/* sv/omni_drive_motor_mixer.sv */
// channel   dir  handshake                 word
// cmd       in   cmd_valid / cmd_stall     in_t: drive command or flow sample
// res       out  res_valid / res_stall     out_t: drive states, levels, estimates
// cfg       in   cfg_valid / cfg_ready     cfg_index selects register, cfg_data
//
// one word per cycle is taken while cmd_stall is low; a drive command passes from the
// queue through the mixer s1 and s2 registers to res, and waits in s2 on res_stall.
// a drive command that follows a flow sample taken in lateral mode waits for
// the drift pid pipeline (s1 to s4) to settle the learned trim.
// reset clears configuration to defaults and all drift state; no clearing pass.
// a two-word queue keeps taking input while a result waits on res_stall, until it is full.
module omni_drive_motor_mixer import odm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  in_t         cmd,
	output logic        res_valid,
	input  logic        res_stall,
	output out_t        res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	logic signed [7:0] so_q;
	logic signed [7:0] lo_q;
	gains_t            gains_q;
	logic [2:0]        last_dir_q;

	logic               q_valid;
	logic               q_pop;
	entry_t             q_word;
	logic               take_ok;
	logic               mix_go;
	logic               pid_start;
	logic               pid_busy;
	logic               lat_mode;
	logic signed [15:0] pid_trim;

	assign cfg_ready = 1'b1;
	assign lat_mode  = (last_dir_q == DIR_LEFT) || (last_dir_q == DIR_RIGHT);

	// drive words wait until the learned trim is final
	assign q_pop     = q_valid && (q_word.is_flow || (take_ok && !pid_busy));
	assign pid_start = q_pop && q_word.is_flow;
	assign mix_go    = q_pop && !q_word.is_flow;

	odm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_word    (q_word)
	);

	odm_pid u_pid (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (pid_start),
		.lateral (lat_mode),
		.delta   (q_word.flow_delta),
		.gains   (gains_q),
		.trim    (pid_trim),
		.busy    (pid_busy)
	);

	odm_mixer u_mixer (
		.clk             (clk),
		.arst_n          (arst_n),
		.go              (mix_go),
		.take_ok         (take_ok),
		.cmd             (q_word),
		.straight_offset (so_q),
		.lateral_offset  (lo_q),
		.trim            (pid_trim),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			so_q       <= '0;
			lo_q       <= '0;
			gains_q.kp <= GAIN_P_RESET;
			gains_q.ki <= GAIN_I_RESET;
			gains_q.kd <= GAIN_D_RESET;
			last_dir_q <= DIR_BRAKE;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_STRAIGHT_OFFSET:   so_q       <= cfg_data[7:0];
					REG_LATERAL_OFFSET:    lo_q       <= cfg_data[7:0];
					REG_GAIN_PROPORTIONAL: gains_q.kp <= cfg_data;
					REG_GAIN_INTEGRAL:     gains_q.ki <= cfg_data;
					REG_GAIN_DERIVATIVE:   gains_q.kd <= cfg_data;
					default: ;
				endcase
			end
			if (mix_go) begin
				last_dir_q <= q_word.direction;
			end
		end
	end

	a_drive_waits_pid: assert property (@(posedge clk) disable iff (!arst_n)
		mix_go |-> !pid_busy)
		else $error("drive word issued while drift pid busy");

	a_clear_trim: assert property (@(posedge clk) disable iff (!arst_n)
		(pid_start && !lat_mode) |=> (pid_trim == 16'sd0))
		else $error("learned trim not cleared by non-lateral flow sample");

	a_one_estimate: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.estimate_x == 16'd0 || res.estimate_y == 16'd0))
		else $error("both estimates nonzero");

endmodule
